>>> design/smps_pkg.sv
`default_nettype none

package smps_pkg;

    // Parameter defaults
    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_ID_BITS    = 16;
    localparam int DEF_VALUE_BITS = 16;

    // Fixed field widths
    localparam int ELEMENT_ID_W = 16;
    localparam int MEMBERSHIP_W = 16;
    localparam int SUM_W        = 33;
    localparam int STATUS_W     = 2;

    // op codes
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_PATTERN = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_SUM      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    typedef struct packed {
        logic                           op;
        logic        [ELEMENT_ID_W-1:0] element_id;
        logic signed [MEMBERSHIP_W-1:0] membership;
        logic                           last;
        logic                           subtract;
    } item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]    pattern_sum;
        logic        [STATUS_W-1:0] status;
    } result_t;

    // search unit handshake
    typedef struct packed {
        logic start;
        logic upper;   // 1: first index above key, 0: first index not below key
    } search_req_t;

    typedef struct packed {
        logic done;
        logic found;   // lower-bound hit: entry at pos has the key
    } search_rsp_t;

endpackage

`default_nettype wire

>>> design/smps_ram.sv
`default_nettype none

module smps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/smps_search.sv
`default_nettype none

module smps_search
    import smps_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int ID_BITS    = DEF_ID_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire search_req_t                          req,
    input  wire logic [ID_BITS-1:0]                   key,
    input  wire logic [$clog2(CAPACITY+1)-1:0]        count,
    output logic                                      rd_en,
    output logic [$clog2(CAPACITY)-1:0]               rd_addr,
    input  wire logic [ID_BITS+VALUE_BITS-1:0]        rd_data,
    output search_rsp_t                               rsp,
    output logic [$clog2(CAPACITY+1)-1:0]             pos,
    output logic [VALUE_BITS-1:0]                     value
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int ENTRY_W = ID_BITS + VALUE_BITS;

    typedef enum logic [2:0] {
        SR_IDLE = 3'b001,
        SR_TEST = 3'b010,
        SR_CMP  = 3'b100
    } sr_state_t;

    sr_state_t             state_reg, state_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [CNT_W-1:0]      mid_reg, mid_next;
    logic                  upper_reg, upper_next;
    logic                  found_reg, found_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    logic [CNT_W-1:0]      mid;
    logic [ID_BITS-1:0]    rd_id;
    logic                  go_right;

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_id    = rd_data[ENTRY_W-1 -: ID_BITS];
    assign go_right = upper_reg ? (rd_id <= key) : (rd_id < key);

    assign rd_addr = mid[ADDR_W-1:0];
    assign pos     = lo_reg;
    assign value   = value_reg;

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        upper_next = upper_reg;
        found_next = found_reg;
        value_next = value_reg;
        rd_en      = 1'b0;
        rsp.done   = 1'b0;
        rsp.found  = found_reg;
        unique case (state_reg)
            SR_IDLE:
            begin
                if (req.start)
                begin
                    lo_next    = '0;
                    hi_next    = count;
                    upper_next = req.upper;
                    found_next = 1'b0;
                    state_next = SR_TEST;
                end
            end
            SR_TEST:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    mid_next   = mid;
                    state_next = SR_CMP;
                end
                else
                begin
                    rsp.done   = 1'b1;
                    state_next = SR_IDLE;
                end
            end
            SR_CMP:
            begin
                if (go_right)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    // if any mid moved hi, the final lower bound is the last mid that did
                    hi_next    = mid_reg;
                    found_next = (rd_id == key);
                    value_next = rd_data[VALUE_BITS-1:0];
                end
                state_next = SR_TEST;
            end
            default:
            begin
                state_next = SR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SR_IDLE;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        upper_reg <= upper_next;
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

>>> design/sparse_membership_pattern_sum.sv
// Pattern word: binary search over n entries, k = ceil(log2(n+1)) or one less
//   probes, each a registered RAM read issued in TEST and compared in CMP.
// Insert: search, then m entries moved up one slot, then the new entry written; full-table insert: no search.
// Next word accepted in the cycle after the result loads (inner pattern word: once its search ends);
//   one word in flight, a finished result waits in the output register until taken.
// Reset (rst_n, async, active low) empties the table, clears sum and default at once.
`default_nettype none

module sparse_membership_pattern_sum
    import smps_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int ID_BITS    = DEF_ID_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input words
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire item_t                          item,
    // result words
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output result_t                             result,
    // default membership register
    input  wire logic                           cfg_wr_en,
    input  wire logic signed [MEMBERSHIP_W-1:0] cfg_wr_data
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int ENTRY_W = ID_BITS + VALUE_BITS;

    // Sequencer: SEARCH runs the shared search unit, SHIFT/MOVE walk the
    // tail of the table up one slot (read, then write) to open the insert slot.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_SHIFT  = 5'b00100,
        ST_MOVE   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [SUM_W-1:0]    run_sum_reg, run_sum_next;
    logic signed [MEMBERSHIP_W-1:0] default_reg, default_next;
    logic                       out_valid_reg, out_valid_next;
    result_t                    out_reg, out_next;

    // latched item
    logic                       op_reg, op_next;
    logic [ID_BITS-1:0]         key_reg, key_next;
    logic [VALUE_BITS-1:0]      val_reg, val_next;
    logic                       last_reg, last_next;
    logic                       sub_reg, sub_next;

    // insert walk and pending result
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic [CNT_W-1:0]           ins_pos_reg, ins_pos_next;
    logic signed [SUM_W-1:0]    pend_sum_reg, pend_sum_next;
    logic [STATUS_W-1:0]        pend_status_reg, pend_status_next;

    // search unit / RAM wiring
    search_req_t                srch_req;
    search_rsp_t                srch_rsp;
    logic [CNT_W-1:0]           srch_pos;
    logic [VALUE_BITS-1:0]      srch_value;
    logic                       srch_rd_en;
    logic [ADDR_W-1:0]          srch_rd_addr;
    logic                       ram_rd_en;
    logic [ADDR_W-1:0]          ram_rd_addr;
    logic [ENTRY_W-1:0]         ram_rd_data;
    logic                       ram_wr_en;
    logic [ADDR_W-1:0]          ram_wr_addr;
    logic [ENTRY_W-1:0]         ram_wr_data;

    logic                       accept;
    logic                       table_full;
    logic [31:0]                id_wide;
    logic [31:0]                val_wide;
    logic [CNT_W-1:0]           idx_dec;
    logic signed [VALUE_BITS-1:0] found_val;
    logic signed [SUM_W-1:0]    term;
    logic signed [SUM_W-1:0]    sum_new;

    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign table_full   = (count_reg == CNT_W'(CAPACITY));
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // only the low ID_BITS of the id and the low VALUE_BITS of the value are kept
    assign id_wide  = 32'(item.element_id);
    assign val_wide = {{(32 - MEMBERSHIP_W){item.membership[MEMBERSHIP_W-1]}}, item.membership};

    assign idx_dec   = idx_reg - CNT_W'(1);
    assign found_val = srch_value;
    assign term      = srch_rsp.found ? SUM_W'(found_val) : SUM_W'(default_reg);
    assign sum_new   = sub_reg ? (run_sum_reg - term) : (run_sum_reg + term);

    // search unit owns the read port while searching
    assign ram_rd_en   = (state_reg == ST_SEARCH) ? srch_rd_en : (state_reg == ST_SHIFT) &&
                         (idx_reg > ins_pos_reg);
    assign ram_rd_addr = (state_reg == ST_SEARCH) ? srch_rd_addr : idx_dec[ADDR_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        run_sum_next     = run_sum_reg;
        default_next     = cfg_wr_en ? cfg_wr_data : default_reg;
        out_valid_next   = out_valid_reg && !result_ready;
        out_next         = out_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        val_next         = val_reg;
        last_next        = last_reg;
        sub_next         = sub_reg;
        idx_next         = idx_reg;
        ins_pos_next     = ins_pos_reg;
        pend_sum_next    = pend_sum_reg;
        pend_status_next = pend_status_reg;
        srch_req.start   = 1'b0;
        srch_req.upper   = 1'b0;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = idx_reg[ADDR_W-1:0];
        ram_wr_data      = ram_rd_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = item.op;
                    key_next  = id_wide[ID_BITS-1:0];
                    val_next  = val_wide[VALUE_BITS-1:0];
                    last_next = item.last;
                    sub_next  = item.subtract;
                    if (item.op == OP_INSERT && table_full)
                    begin
                        pend_sum_next    = '0;
                        pend_status_next = STATUS_FULL;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        // insert: upper bound, duplicates land after existing ids
                        srch_req.start = 1'b1;
                        srch_req.upper = (item.op == OP_INSERT);
                        state_next     = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (srch_rsp.done)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        idx_next     = count_reg;
                        ins_pos_next = srch_pos;
                        state_next   = ST_SHIFT;
                    end
                    else if (last_reg)
                    begin
                        pend_sum_next    = sum_new;
                        pend_status_next = STATUS_SUM;
                        run_sum_next     = '0;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        run_sum_next = sum_new;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (idx_reg > ins_pos_reg)
                begin
                    // read of slot idx-1 issued here
                    state_next = ST_MOVE;
                end
                else
                begin
                    ram_wr_en        = 1'b1;
                    ram_wr_data      = {key_reg, val_reg};
                    count_next       = count_reg + CNT_W'(1);
                    pend_sum_next    = '0;
                    pend_status_next = STATUS_INSERTED;
                    state_next       = ST_DONE;
                end
            end
            ST_MOVE:
            begin
                ram_wr_en  = 1'b1;
                idx_next   = idx_dec;
                state_next = ST_SHIFT;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next         = 1'b1;
                    out_next.pattern_sum   = pend_sum_reg;
                    out_next.status        = pend_status_reg;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            run_sum_reg   <= '0;
            default_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            run_sum_reg   <= run_sum_next;
            default_reg   <= default_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg         <= out_next;
        op_reg          <= op_next;
        key_reg         <= key_next;
        val_reg         <= val_next;
        last_reg        <= last_next;
        sub_reg         <= sub_next;
        idx_reg         <= idx_next;
        ins_pos_reg     <= ins_pos_next;
        pend_sum_reg    <= pend_sum_next;
        pend_status_reg <= pend_status_next;
    end

    smps_search #(
        .CAPACITY   (CAPACITY),
        .ID_BITS    (ID_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (srch_req),
        .key     (key_reg),
        .count   (count_reg),
        .rd_en   (srch_rd_en),
        .rd_addr (srch_rd_addr),
        .rd_data (ram_rd_data),
        .rsp     (srch_rsp),
        .pos     (srch_pos),
        .value   (srch_value)
    );

    // entry = {id, value}
    smps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

>>> design/smps_checker.sv
`default_nettype none

module smps_checker
    import smps_pkg::*;
(
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           item_valid,
    input wire logic                           item_ready,
    input wire item_t                          item,
    input wire logic                           result_valid,
    input wire logic                           result_ready,
    input wire result_t                        result,
    input wire logic                           cfg_wr_en,
    input wire logic signed [MEMBERSHIP_W-1:0] cfg_wr_data
);

    // stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("ready high right after accept");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == STATUS_SUM) || (result.status == STATUS_INSERTED) ||
                         (result.status == STATUS_FULL))
        else $error("bad status code");

    a_insert_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != STATUS_SUM) |-> (result.pattern_sum == '0))
        else $error("insert result carries nonzero sum");

endmodule

bind sparse_membership_pattern_sum smps_checker u_checker (.*);

`default_nettype wire
